/* rtl/clipped_alpha_blend_blit_macros.svh */
// Assertion macros shared by the clipped alpha blend blitter.
`ifndef CLIPPED_ALPHA_BLEND_BLIT_MACROS_SVH
`define CLIPPED_ALPHA_BLEND_BLIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CBB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CBB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/cbb_pkg.sv */
// Types and constants of the clipped alpha blend blitter.
`default_nettype none
package cbb_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] REG_DEST_LEFT     = 3'd1;
  localparam logic [2:0] REG_DEST_TOP      = 3'd2;
  localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd3;
  localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd4;

  localparam int unsigned CFG_W = 13;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH   = 13'd1;
  localparam logic [CFG_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
  localparam logic [CFG_W-1:0] RST_SCREEN_HEIGHT = 13'd480;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic        [CFG_W-1:0] image_width;
    logic signed [CFG_W-1:0] dest_left;
    logic signed [CFG_W-1:0] dest_top;
    logic        [CFG_W-1:0] screen_width;
    logic        [CFG_W-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
    logic [7:0]  src_alpha;
    logic [31:0] background_pixel;
    logic        last_of_image;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] write_address;
    logic [31:0] pixel_out;
    logic        end_of_image;
  } out_item_t;

  // Position status handed from the position unit to the top level.
  typedef struct packed {
    logic        visible;
    logic [23:0] addr;
  } pos_t;

endpackage
`default_nettype wire

/* rtl/clipped_alpha_blend_blit.sv */
// An accepted result is registered in out_r, or in skid_r while out_r is held.
// One item per cycle while skid_r is empty; blend and address multiply are one stage.
// A two-entry output (register plus skid) keeps input ready while a result waits.
// Reset (rst_n low, synchronous) empties the output, zeroes the counters and
// loads the configuration defaults.
`default_nettype none
`include "clipped_alpha_blend_blit_macros.svh"
module clipped_alpha_blend_blit
  import cbb_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t      cfg_r;
  pos_t      pos;
  logic [23:0] mix_rgb;
  out_item_t res;
  out_item_t out_r, skid_r;
  logic      out_valid_r, skid_valid_r;
  logic      in_fire, out_fire, write_en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width   <= RST_IMAGE_WIDTH;
      cfg_r.dest_left     <= '0;
      cfg_r.dest_top      <= '0;
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:   cfg_r.image_width   <= cfg_data;
        REG_DEST_LEFT:     cfg_r.dest_left     <= $signed(cfg_data);
        REG_DEST_TOP:      cfg_r.dest_top      <= $signed(cfg_data);
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_fire  = out_valid_r && out_ready;
  assign out_data  = out_r;

  cbb_pos #(
    .MAX_DIM(MAX_DIM)
  ) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .advance (in_fire),
    .last    (in_data.last_of_image),
    .pos     (pos)
  );

  cbb_blend u_blend (
    .alpha   (in_data.src_alpha),
    .src_rgb ({in_data.src_red, in_data.src_green, in_data.src_blue}),
    .bg_rgb  (in_data.background_pixel[23:0]),
    .mix_rgb (mix_rgb)
  );

  // Result item; nothing is written for a clipped or fully transparent pixel.
  always_comb begin
    write_en          = pos.visible && (in_data.src_alpha != '0);
    res.write_enable  = write_en;
    res.write_address = write_en ? pos.addr : '0;
    res.pixel_out     = write_en ? {ALPHA_OPAQUE, mix_rgb} : '0;
    res.end_of_image  = in_data.last_of_image;
  end

  // Output register with skid entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_r        <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_r       <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r       <= res;
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  // Checks on the output buffering and the result fields.
  `CBB_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid entry without output item")
  `CBB_ASSERT_NEXT(a_stall_fills_skid, in_fire && out_valid_r && !out_ready, skid_valid_r, "item lost on output stall")
  `CBB_ASSERT_NOW(a_idle_fields_zero, out_valid_r && !out_r.write_enable, (out_r.write_address == '0) && (out_r.pixel_out == '0), "nonzero fields without write")
  `CBB_ASSERT_NOW(a_alpha_forced, out_valid_r && out_r.write_enable, out_r.pixel_out[31:24] == ALPHA_OPAQUE, "written pixel alpha not opaque")

endmodule
`default_nettype wire

/* rtl/cbb_pos.sv */
// Column and row counters, destination placement, clipping and address.
`default_nettype none
module cbb_pos
  import cbb_pkg::*;
#(
  parameter int unsigned MAX_DIM = 4096
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic advance,
  input  wire logic last,
  output pos_t      pos
);

  localparam int unsigned CNT_W = $clog2(MAX_DIM);
  localparam int unsigned CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam int unsigned POS_W = CMP_W + 1;

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CMP_W-1:0] col_inc, row_inc;
  logic             col_wrap, row_wrap;
  logic signed [POS_W-1:0] x_pos, y_pos;
  logic [CMP_W-1:0] x_u, y_u;
  logic             on_screen;
  logic [2*CFG_W-1:0] row_base;
  logic [2*CFG_W-1:0] addr_sum;

  // Row end: a zero width wraps every item, a width beyond the bound acts as the bound.
  always_comb begin
    col_inc  = CMP_W'(col_r) + CMP_W'(1);
    row_inc  = CMP_W'(row_r) + CMP_W'(1);
    col_wrap = (col_inc >= CMP_W'(cfg.image_width)) || (col_inc >= CMP_W'(MAX_DIM));
    row_wrap = (row_inc >= CMP_W'(MAX_DIM));
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_wrap) begin
      col_nxt = '0;
      row_nxt = row_wrap ? '0 : row_inc[CNT_W-1:0];
    end else begin
      col_nxt = col_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Screen position of the current item and clip test.
  always_comb begin
    x_pos = POS_W'(cfg.dest_left) + POS_W'($signed({1'b0, col_r}));
    y_pos = POS_W'(cfg.dest_top) + POS_W'($signed({1'b0, row_r}));
    x_u   = x_pos[CMP_W-1:0];
    y_u   = y_pos[CMP_W-1:0];
    on_screen = !x_pos[POS_W-1] && !y_pos[POS_W-1] &&
                (x_u < CMP_W'(cfg.screen_width)) &&
                (y_u < CMP_W'(cfg.screen_height));
  end

  // Linear address; on screen both coordinates fit the register width.
  always_comb begin
    row_base = y_u[CFG_W-1:0] * cfg.screen_width;
    addr_sum = row_base + (2*CFG_W)'(x_u[CFG_W-1:0]);
    pos.visible = on_screen;
    pos.addr    = addr_sum[23:0];
  end

endmodule
`default_nettype wire

/* rtl/cbb_blend.sv */
// Per-channel alpha blend of source over background, divided by 255.
`default_nettype none
module cbb_blend
  import cbb_pkg::*;
(
  input  wire logic [7:0]  alpha,
  input  wire logic [23:0] src_rgb,
  input  wire logic [23:0] bg_rgb,
  output logic      [23:0] mix_rgb
);

  logic [7:0] inv_alpha;

  // Exact floor(n / 255) for any n up to 255 * 255, the largest blend sum.
  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [16:0] t;
    t = 17'(n) + 17'(n[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // One product pair per channel; alpha 255 gives the source color exactly.
  always_comb begin
    logic [15:0] sum;
    inv_alpha = ALPHA_OPAQUE - alpha;
    for (int i = 0; i < 3; i++) begin
      sum = src_rgb[8*i +: 8] * alpha + bg_rgb[8*i +: 8] * inv_alpha;
      mix_rgb[8*i +: 8] = div255(sum);
    end
  end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the clipped alpha blend blitter: probes, corners, random images.
`timescale 1ns / 1ps
module tb_top;
  import cbb_pkg::*;

  localparam int IMG_MAX = 4096;
  localparam int RANDOM_ITEMS = 460;
  localparam int CALM_ITEMS = 120;

  // One directed probe: the pixel to send and, where obvious, the result it must give.
  typedef struct packed {
    in_item_t  px;
    logic      known;
    out_item_t want;
  } probe_t;

  localparam int N_PROBES = 10;
  localparam probe_t PROBES [N_PROBES] = '{
    '{'{8'hFF, 8'h00, 8'hFF, 8'hFF, 32'h0000_0000, 1'b0}, 1'b1,
      '{1'b1, 24'd0, 32'hFFFF_00FF, 1'b0}},
    '{'{8'h12, 8'h34, 8'h56, 8'h00, 32'hDEAD_BEEF, 1'b0}, 1'b1,
      '{1'b0, 24'd0, 32'h0000_0000, 1'b0}},
    '{'{8'hFF, 8'h00, 8'h80, 8'h80, 32'h0000_FF40, 1'b0}, 1'b0, '0},
    '{'{8'hFF, 8'hFF, 8'hFF, 8'h01, 32'hFF00_0000, 1'b0}, 1'b0, '0},
    '{'{8'h00, 8'h00, 8'h00, 8'hFE, 32'hFFFF_FFFF, 1'b0}, 1'b0, '0},
    '{'{8'h00, 8'hFF, 8'h00, 8'hFF, 32'hA5A5_A5A5, 1'b1}, 1'b1,
      '{1'b1, 24'd3200, 32'hFF00_FF00, 1'b1}},
    '{'{8'h01, 8'h02, 8'h03, 8'hFF, 32'h0000_0000, 1'b0}, 1'b1,
      '{1'b1, 24'd0, 32'hFF01_0203, 1'b0}},
    '{'{8'hFF, 8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b1}, 1'b1,
      '{1'b0, 24'd0, 32'h0000_0000, 1'b1}},
    '{'{8'hAA, 8'h55, 8'hF0, 8'h7F, 32'h0F0F_0F0F, 1'b0}, 1'b0, '0},
    '{'{8'h5A, 8'hA5, 8'hC3, 8'h81, 32'hF0F0_F0F0, 1'b1}, 1'b0, '0}
  };

  // Settings at the edges of the register ranges.
  localparam int N_CORNERS = 8;
  localparam cfg_t CORNERS [N_CORNERS] = '{
    '{13'd0,    13'sd0,     13'sd0,     13'd640,  13'd480},
    '{13'd8191, -13'sd5,    13'sd0,     13'd16,   13'd8},
    '{13'd7,    -13'sd3,    -13'sd2,    13'd5,    13'd4},
    '{13'd4096, 13'sd4095,  13'sd4095,  13'd8191, 13'd8191},
    '{13'd5,    -13'sd4096, -13'sd4096, 13'd4096, 13'd4096},
    '{13'd3,    13'sd0,     13'sd0,     13'd0,    13'd480},
    '{13'd3,    13'sd0,     13'sd0,     13'd640,  13'd0},
    '{13'd2,    13'sd1,     13'sd1,     13'd1,    13'd1}
  };

  // One column, every row on screen: the address equals the row.
  localparam cfg_t TALL_SET = '{13'd1, 13'sd0, 13'sd0, 13'd1, 13'd4096};

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  // Mirror of the block's registers and raster counters.
  int img_w = int'(RST_IMAGE_WIDTH);
  int dst_left = 0;
  int dst_top = 0;
  int scr_w = int'(RST_SCREEN_WIDTH);
  int scr_h = int'(RST_SCREEN_HEIGHT);
  int col_pos = 0;
  int row_pos = 0;

  out_item_t pending_pixels [$];
  bit        calm = 1'b0;
  int        errs = 0;
  int        n_items = 0;
  int        n_results = 0;
  int        n_writes = 0;
  int        n_blends = 0;
  int        n_settings = 0;

  clipped_alpha_blend_blit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // The result side stalls at random unless a calm stretch is running.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 29);
  end

  function automatic int eff_width(int w);
    if (w == 0) return 1;
    if (w > IMG_MAX) return IMG_MAX;
    return w;
  endfunction

  function automatic logic [7:0] mix8(int s, int b, int a);
    int full;
    full = int'(ALPHA_OPAQUE);
    return 8'((s * a + b * (full - a)) / full);
  endfunction

  // Works out the result of one pixel and advances the raster counters.
  function automatic out_item_t blend_step(in_item_t px);
    out_item_t res;
    int        x;
    int        y;
    int        a;
    res = '0;
    res.end_of_image = px.last_of_image;
    x = dst_left + col_pos;
    y = dst_top + row_pos;
    a = int'(px.src_alpha);
    if (x >= 0 && y >= 0 && x < scr_w && y < scr_h && a != 0) begin
      res.write_enable = 1'b1;
      res.write_address = 24'(y * scr_w + x);
      n_writes++;
      if (px.src_alpha == ALPHA_OPAQUE) begin
        res.pixel_out = {ALPHA_OPAQUE, px.src_red, px.src_green, px.src_blue};
      end else begin
        n_blends++;
        res.pixel_out = {ALPHA_OPAQUE,
                         mix8(px.src_red, px.background_pixel[23:16], a),
                         mix8(px.src_green, px.background_pixel[15:8], a),
                         mix8(px.src_blue, px.background_pixel[7:0], a)};
      end
    end
    if (px.last_of_image) begin
      col_pos = 0;
      row_pos = 0;
    end else if (col_pos + 1 >= eff_width(img_w)) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= IMG_MAX) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  function automatic in_item_t random_pixel();
    in_item_t px;
    int       pick;
    pick = $urandom_range(99);
    px.src_red = 8'($urandom);
    px.src_green = 8'($urandom);
    px.src_blue = 8'($urandom);
    px.background_pixel = $urandom;
    px.last_of_image = 1'b0;
    if (pick < 20) px.src_alpha = 8'h00;
    else if (pick < 40) px.src_alpha = ALPHA_OPAQUE;
    else if (pick < 45) px.src_alpha = 8'h01;
    else if (pick < 50) px.src_alpha = 8'hFE;
    else px.src_alpha = 8'($urandom);
    return px;
  endfunction

  // Offsets are mostly small so that images straddle the screen edges.
  function automatic logic [CFG_W-1:0] rand_offset();
    if ($urandom_range(99) < 15) return CFG_W'($urandom);
    return CFG_W'(int'($urandom_range(18)) - 6);
  endfunction

  function automatic logic [CFG_W-1:0] rand_screen();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 18) return CFG_W'($urandom);
    return CFG_W'($urandom_range(1, 16));
  endfunction

  task automatic note_failure(string what, out_item_t got, out_item_t want);
    errs++;
    if (errs <= 10) begin
      $display("%0t %s: got we=%0b addr=%h pix=%h eoi=%0b,",
               $time, what, got.write_enable, got.write_address, got.pixel_out,
               got.end_of_image);
      $display("    expected we=%0b addr=%h pix=%h eoi=%0b",
               want.write_enable, want.write_address, want.pixel_out,
               want.end_of_image);
    end
  endtask

  // Results are sampled at the falling edge; they are taken at the next rising edge.
  always @(negedge clk) begin : watch_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_pixels.size() == 0) begin
        note_failure("unexpected result", out_data, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data.write_enable !== want.write_enable ||
            out_data.write_address !== want.write_address ||
            out_data.pixel_out !== want.pixel_out ||
            out_data.end_of_image !== want.end_of_image)
          note_failure("result mismatch", out_data, want);
      end
    end
  end

  // Offers one item, waits for its acceptance and queues what it must give.
  task automatic push_pixel(in_item_t px, logic known, out_item_t want);
    out_item_t pred;
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= px;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pred = blend_step(px);
    pending_pixels.push_back(known ? want : pred);
    n_items++;
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:   img_w = int'(val);
      REG_DEST_LEFT:     dst_left = int'($signed(val));
      REG_DEST_TOP:      dst_top = int'($signed(val));
      REG_SCREEN_WIDTH:  scr_w = int'(val);
      REG_SCREEN_HEIGHT: scr_h = int'(val);
      default: ;
    endcase
  endtask

  // Registers change only with the block drained and quiet.
  task automatic apply_setting(cfg_t s);
    wait_drain();
    repeat (2) @(posedge clk);
    write_reg(REG_IMAGE_WIDTH, s.image_width);
    write_reg(REG_DEST_LEFT, s.dest_left);
    write_reg(REG_DEST_TOP, s.dest_top);
    write_reg(REG_SCREEN_WIDTH, s.screen_width);
    write_reg(REG_SCREEN_HEIGHT, s.screen_height);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // A clean image is whole rows, cut to 48 items at most, ending in the last flag; a noisy one has stray flags.
  task automatic send_image(bit noisy);
    int       n;
    in_item_t px;
    n = noisy ? int'($urandom_range(1, 30)) : eff_width(img_w) * int'($urandom_range(1, 4));
    if (n > 48) n = 48;
    for (int i = 0; i < n; i++) begin
      px = random_pixel();
      if (i == n - 1) px.last_of_image = !noisy || ($urandom_range(1) == 1);
      else px.last_of_image = noisy && ($urandom_range(9) == 0);
      push_pixel(px, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    cfg_t s;
    int   random_start;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed probes at the reset settings.
    for (int i = 0; i < N_PROBES; i++) begin
      push_pixel(PROBES[i].px, PROBES[i].known, PROBES[i].want);
    end

    // Corner settings, a few images each.
    for (int i = 0; i < N_CORNERS; i++) begin
      apply_setting(CORNERS[i]);
      repeat (3) send_image(1'b0);
    end

    // A run of rows without a last flag, no idling on either side.
    apply_setting(TALL_SET);
    calm = 1'b1;
    for (int i = 0; i < CALM_ITEMS; i++) begin
      push_pixel(random_pixel(), 1'b0, '0);
    end
    calm = 1'b0;

    // Random settings with mostly clean images.
    random_start = n_items;
    while (n_items - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(19))
        0: s.image_width = '0;
        1: s.image_width = CFG_W'($urandom_range(IMG_MAX + 1, 8191));
        2: s.image_width = CFG_W'(IMG_MAX);
        default: s.image_width = CFG_W'($urandom_range(1, 10));
      endcase
      s.dest_left = rand_offset();
      s.dest_top = rand_offset();
      s.screen_width = rand_screen();
      s.screen_height = rand_screen();
      apply_setting(s);
      repeat ($urandom_range(1, 4)) send_image($urandom_range(99) < 15);
    end

    wait_drain();
    repeat (4) @(posedge clk);
    $display("Ran %0d items under %0d register settings; %0d results, %0d writes, %0d blends.",
             n_items, n_settings, n_results, n_writes, n_blends);
    $display("Covered zero and oversize widths, empty screens, address wrap and a stall-free run.");
    if (errs == 0 && pending_pixels.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
